### rtl/deq_pkg.sv
// Shared codes and types for the double-ended queue with search.
// Holds request codes, status codes and the default store depth.
// No dependencies; imported by double_ended_queue_with_search.
package deq_pkg;

    typedef logic [2:0] func_t;
    typedef logic [1:0] status_t;
    typedef logic signed [31:0] word_t;

    localparam func_t FUNC_PUSH_FRONT = 3'd0;
    localparam func_t FUNC_PUSH_REAR  = 3'd1;
    localparam func_t FUNC_POP_FRONT  = 3'd2;
    localparam func_t FUNC_POP_REAR   = 3'd3;
    localparam func_t FUNC_SEARCH     = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int DEQ_DEPTH = 16;

endpackage

### rtl/double_ended_queue_with_search.sv
// Bounded double-ended queue of signed 32-bit words with linear search.
// Ring store in a single-port-write, registered-read memory, one sequencer.
// Depends on deq_pkg.
//
// Usage:
//   Requests arrive on the in channel (in_valid/in_ready) carrying func and
//   value. Each request yields exactly one result transaction on the out
//   channel (out_valid/out_ready) carrying status, popped_value, found and
//   fill_count. One request is in flight at a time: in_ready is high only
//   while the sequencer is idle and no result is waiting.
//   A push, an unused code or a refused pop/search goes straight to the
//   result. A successful pop passes through one registered memory read
//   (state S_POP) first. A search on a non-empty store steps through the
//   occupied entries in S_SCAN; one entry is read and compared each cycle.
//   A stalled receiver simply holds the result: out_valid and the payload
//   stay put and no new request is accepted until the result is taken.
//   Reset empties the queue (front position and occupancy to zero); the
//   store itself is not cleared, only written entries are ever read.
module double_ended_queue_with_search #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  deq_pkg::func_t                 func,
    input  deq_pkg::word_t                 value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output deq_pkg::status_t               status,
    output deq_pkg::word_t                 popped_value,
    output logic                           found,
    output logic [$clog2(DEPTH + 1) - 1:0] fill_count
);
    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_POS  = PW'(DEPTH - 1);

    // Sequencer state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // Fold a sum below twice the depth back into the ring
    function automatic logic [PW-1:0] wrap_pos(input logic [CW:0] s);
        logic [CW:0] t;
        begin
            t = (s >= DEPTH_EXT) ? s - DEPTH_EXT : s;
            return t[PW-1:0];
        end
    endfunction

    // Store
    word_t          entries_reg [DEPTH];
    word_t          rd_data_reg;

    // Control and payload registers
    logic [1:0]     state_reg,  state_next;
    logic [PW-1:0]  front_reg,  front_next;
    logic [CW-1:0]  occ_reg,    occ_next;
    logic [CW-1:0]  idx_reg,    idx_next;
    word_t          key_reg,    key_next;
    status_t        status_reg, status_next;
    word_t          popped_reg, popped_next;
    logic           found_reg,  found_next;

    logic           in_fire;
    logic           out_fire;
    logic           is_full;
    logic           is_empty;
    logic           wr_en;
    logic [PW-1:0]  wr_addr;
    logic [PW-1:0]  rd_addr;
    logic [CW:0]    front_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign is_full   = (occ_reg == DEPTH_CNT);
    assign is_empty  = (occ_reg == '0);
    assign front_ext = (CW + 1)'(front_reg);

    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign found        = found_reg;
    assign fill_count   = occ_reg;

    // Sequencer: decode the request on acceptance, then pop or scan
    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        occ_next    = occ_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        status_next = status_reg;
        popped_next = popped_reg;
        found_next  = found_reg;
        wr_en       = 1'b0;
        wr_addr     = wrap_pos(front_ext + (CW + 1)'(occ_reg));
        rd_addr     = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next = ST_OK;
                    popped_next = '0;
                    found_next  = 1'b0;
                    key_next    = value;
                    state_next  = S_OUT;
                    unique case (func)
                        FUNC_PUSH_FRONT:
                        begin
                            if (is_full)
                                status_next = ST_FULL;
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = (front_reg == '0) ? LAST_POS
                                                               : front_reg - 1'b1;
                                front_next = wr_addr;
                                occ_next   = occ_reg + 1'b1;
                            end
                        end
                        FUNC_PUSH_REAR:
                        begin
                            if (is_full)
                                status_next = ST_FULL;
                            else
                            begin
                                wr_en    = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        FUNC_POP_FRONT:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                rd_addr    = front_reg;
                                front_next = wrap_pos(front_ext + 1'b1);
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        FUNC_POP_REAR:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                rd_addr    = wrap_pos(front_ext + (CW + 1)'(occ_reg)
                                                      - 1'b1);
                                occ_next   = occ_reg - 1'b1;
                                state_next = S_POP;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                // Issue the read of the front entry now
                                rd_addr    = front_reg;
                                idx_next   = CW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            // Unused codes: no operation
                        end
                    endcase
                end
            end
            S_POP:
            begin
                popped_next = rd_data_reg;
                state_next  = S_OUT;
            end
            S_SCAN:
            begin
                // Compare the entry read last cycle, issue the next read
                if (rd_data_reg == key_reg)
                    found_next = 1'b1;
                rd_addr = wrap_pos(front_ext + (CW + 1)'(idx_reg));
                if (idx_reg == occ_reg)
                    state_next = S_OUT;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_OUT:
            begin
                if (out_fire)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            occ_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            occ_reg   <= occ_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entries_reg[wr_addr] <= value;
        rd_data_reg <= entries_reg[rd_addr];
    end

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_CNT)
        else $error("occupancy beyond store depth");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_full && (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_REAR))
        |=> ($stable(occ_reg) && $stable(front_reg)))
        else $error("refused push changed the queue");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= occ_reg && idx_reg != '0))
        else $error("search index outside stored range");

    a_fail_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_OK) |-> (popped_reg == '0 && !found_reg))
        else $error("refused request carries data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg == ST_FULL) |-> is_full)
        else $error("full status with spare room");

endmodule
